FILE: src/hpack_pkg.sv
// ---------------------------------------------------------------------------
// hpack_pkg
// shared types, constants and code tables for the hpack huffman decoder
// ---------------------------------------------------------------------------
package hpack_pkg;

    localparam int MAX_CODE_LEN     = 30;
    localparam int MIN_CODE_LEN     = 5;
    localparam int NUM_CODE_LENGTHS = 21;
    localparam int NUM_SYMBOLS      = 257;
    localparam int BUF_W            = 40;
    localparam int CNT_W            = 6;

    localparam logic [2:0] ST_SYMBOL   = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_EOS      = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_PADDING  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;      // append input byte
        logic consume;   // drop matched code, count symbol
        logic clear;     // clear string state
        logic set_hold;  // enter error hold
        logic emit_sym;  // symbol word on the output, held while it waits
    } hpack_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       hold;
        logic       match;
        logic       is_eos;
        logic       too_long;
        logic       at_limit;
        logic       pad_bad;
    } hpack_stat_t;

    function automatic logic [4:0] grp_len(input logic [4:0] g);
        case (g)
            5'd0: grp_len = 5'd5;   5'd1: grp_len = 5'd6;   5'd2: grp_len = 5'd7;
            5'd3: grp_len = 5'd8;   5'd4: grp_len = 5'd10;  5'd5: grp_len = 5'd11;
            5'd6: grp_len = 5'd12;  5'd7: grp_len = 5'd13;  5'd8: grp_len = 5'd14;
            5'd9: grp_len = 5'd15;  5'd10: grp_len = 5'd19; 5'd11: grp_len = 5'd20;
            5'd12: grp_len = 5'd21; 5'd13: grp_len = 5'd22; 5'd14: grp_len = 5'd23;
            5'd15: grp_len = 5'd24; 5'd16: grp_len = 5'd25; 5'd17: grp_len = 5'd26;
            5'd18: grp_len = 5'd27; 5'd19: grp_len = 5'd28; 5'd20: grp_len = 5'd30;
            default: grp_len = 5'd30;
        endcase
    endfunction

    function automatic logic [29:0] grp_first(input logic [4:0] g);
        case (g)
            5'd0: grp_first = 30'h0;        5'd1: grp_first = 30'h14;
            5'd2: grp_first = 30'h5c;       5'd3: grp_first = 30'hf8;
            5'd4: grp_first = 30'h3f8;      5'd5: grp_first = 30'h7fa;
            5'd6: grp_first = 30'hffa;      5'd7: grp_first = 30'h1ff8;
            5'd8: grp_first = 30'h3ffc;     5'd9: grp_first = 30'h7ffc;
            5'd10: grp_first = 30'h7fff0;   5'd11: grp_first = 30'hfffe6;
            5'd12: grp_first = 30'h1fffdc;  5'd13: grp_first = 30'h3fffd2;
            5'd14: grp_first = 30'h7fffd8;  5'd15: grp_first = 30'hffffea;
            5'd16: grp_first = 30'h1ffffec; 5'd17: grp_first = 30'h3ffffe0;
            5'd18: grp_first = 30'h7ffffde; 5'd19: grp_first = 30'hfffffe2;
            5'd20: grp_first = 30'h3ffffffc;
            default: grp_first = 30'h3ffffffc;
        endcase
    endfunction

    function automatic logic [5:0] grp_count(input logic [4:0] g);
        case (g)
            5'd0: grp_count = 6'd10;  5'd1: grp_count = 6'd26;  5'd2: grp_count = 6'd32;
            5'd3: grp_count = 6'd6;   5'd4: grp_count = 6'd5;   5'd5: grp_count = 6'd3;
            5'd6: grp_count = 6'd2;   5'd7: grp_count = 6'd6;   5'd8: grp_count = 6'd2;
            5'd9: grp_count = 6'd3;   5'd10: grp_count = 6'd3;  5'd11: grp_count = 6'd8;
            5'd12: grp_count = 6'd13; 5'd13: grp_count = 6'd26; 5'd14: grp_count = 6'd29;
            5'd15: grp_count = 6'd12; 5'd16: grp_count = 6'd4;  5'd17: grp_count = 6'd15;
            5'd18: grp_count = 6'd19; 5'd19: grp_count = 6'd29; 5'd20: grp_count = 6'd4;
            default: grp_count = 6'd0;
        endcase
    endfunction

    // offset of each group within the canonical symbol order
    function automatic logic [8:0] grp_base(input logic [4:0] g);
        case (g)
            5'd0: grp_base = 9'd0;    5'd1: grp_base = 9'd10;   5'd2: grp_base = 9'd36;
            5'd3: grp_base = 9'd68;   5'd4: grp_base = 9'd74;   5'd5: grp_base = 9'd79;
            5'd6: grp_base = 9'd82;   5'd7: grp_base = 9'd84;   5'd8: grp_base = 9'd90;
            5'd9: grp_base = 9'd92;   5'd10: grp_base = 9'd95;  5'd11: grp_base = 9'd98;
            5'd12: grp_base = 9'd106; 5'd13: grp_base = 9'd119; 5'd14: grp_base = 9'd145;
            5'd15: grp_base = 9'd174; 5'd16: grp_base = 9'd186; 5'd17: grp_base = 9'd190;
            5'd18: grp_base = 9'd205; 5'd19: grp_base = 9'd224; 5'd20: grp_base = 9'd253;
            default: grp_base = 9'd0;
        endcase
    endfunction

    localparam logic [4:0] SYM_LEN [NUM_SYMBOLS] = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
         6,10,10,12,13, 6, 8,11,10,10, 8,11, 8, 6, 6, 6,
         5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8,15, 6,12,10,
        13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
         7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8,13,19,13,14, 6,
        15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
         6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26,
        30
    };

    // symbol at each canonical position (symbols sorted by length, then value)
    function automatic logic [8:0] canon_symbol(input logic [8:0] pos);
        logic [8:0] rank;
        logic [8:0] res;
        rank = 9'd0;
        res  = 9'd256;
        for (int l = MIN_CODE_LEN; l <= MAX_CODE_LEN; l++) begin
            for (int s = 0; s < NUM_SYMBOLS; s++) begin
                if (int'(SYM_LEN[s]) == l) begin
                    if (rank == pos) res = 9'(s);
                    rank = rank + 9'd1;
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: src/hpack_ctrl.sv
// ---------------------------------------------------------------------------
// hpack_ctrl
// sequencer: loads a byte, drains symbols one a cycle while the sink is ready, closes the string
// ---------------------------------------------------------------------------
module hpack_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_last,
    input  hpack_pkg::hpack_stat_t stat,
    output hpack_pkg::hpack_cmd_t  cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_done,
    output logic [2:0]            out_status
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DRAIN = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // decode step in drain state
    logic       err;
    logic [2:0] err_code;
    always_comb begin
        err      = 1'b0;
        err_code = hpack_pkg::ST_INVALID;
        if (!stat.match) begin
            if (stat.too_long) err = 1'b1;
        end else if (stat.is_eos) begin
            err = 1'b1; err_code = hpack_pkg::ST_EOS;
        end else if (stat.at_limit) begin
            err = 1'b1; err_code = hpack_pkg::ST_OVERFLOW;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_done   = 1'b0;
        out_status = hpack_pkg::ST_SYMBOL;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (stat.hold) begin
                        if (in_last) cmd.clear = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        last_next  = in_last;
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (err) begin
                    out_valid  = 1'b1;
                    out_done   = 1'b1;
                    out_status = err_code;
                    if (out_ready) begin
                        if (last_reg) cmd.clear = 1'b1;
                        else cmd.set_hold = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (stat.match) begin
                    out_valid    = 1'b1;
                    cmd.emit_sym = 1'b1;
                    if (out_ready) cmd.consume = 1'b1;
                end else if (last_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                out_valid  = 1'b1;
                out_done   = 1'b1;
                out_status = stat.pad_bad ? hpack_pkg::ST_PADDING : hpack_pkg::ST_OK;
                if (out_ready) begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.consume, cmd.clear, cmd.set_hold}))
        else $error("conflicting commands");
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> out_valid && out_done) else $error("close missing");
endmodule

FILE: src/hpack_dpath.sv
// ---------------------------------------------------------------------------
// hpack_dpath
// bit buffer, counters and the canonical code matcher
// ---------------------------------------------------------------------------
module hpack_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hpack_pkg::hpack_cmd_t  cmd,
    input  logic [7:0]            in_byte,
    input  logic [15:0]           output_limit,
    output hpack_pkg::hpack_stat_t stat,
    output logic [7:0]            symbol,
    output logic [15:0]           count
);
    logic [hpack_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [hpack_pkg::CNT_W-1:0] bits_reg, bits_next;
    logic [15:0]                 cnt_reg, cnt_next;
    logic                        hold_reg, hold_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            bits_reg <= '0;
            cnt_reg  <= '0;
            hold_reg <= 1'b0;
        end else begin
            buf_reg  <= buf_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            hold_reg <= hold_next;
        end
    end

    // head window: top 30 valid bits, left aligned
    logic [63:0] shifted;
    logic [29:0] head;
    always_comb begin
        shifted = {24'd0, buf_reg} << (7'd64 - {1'b0, bits_reg});
        head    = shifted[63:34];
    end

    // first matching group by length
    logic       hit;
    logic [4:0] hit_len;
    logic [8:0] hit_pos;
    always_comb begin
        logic [29:0] code;
        logic [29:0] off;
        logic [4:0]  l;
        hit     = 1'b0;
        hit_len = '0;
        hit_pos = '0;
        for (int g = hpack_pkg::NUM_CODE_LENGTHS - 1; g >= 0; g--) begin
            l    = hpack_pkg::grp_len(5'(g));
            code = head >> (5'd30 - l);
            off  = code - hpack_pkg::grp_first(5'(g));
            if ({1'b0, l} <= bits_reg && code >= hpack_pkg::grp_first(5'(g))
                && off < 30'(hpack_pkg::grp_count(5'(g)))) begin
                hit     = 1'b1;
                hit_len = l;
                hit_pos = hpack_pkg::grp_base(5'(g)) + off[8:0];
            end
        end
    end

    logic [8:0] sym9;
    assign sym9 = hpack_pkg::canon_symbol(hit_pos);

    logic [7:0] pmask;
    assign pmask = 8'((9'd1 << bits_reg[2:0]) - 9'd1);

    always_comb begin
        stat.hold     = hold_reg;
        stat.match    = hit;
        stat.is_eos   = sym9[8];
        stat.too_long = bits_reg >= 6'(hpack_pkg::MAX_CODE_LEN);
        stat.at_limit = cnt_reg >= output_limit;
        stat.pad_bad  = (bits_reg >= 6'd8) || ((buf_reg[7:0] & pmask) != pmask);
    end

    // held stable while a symbol word waits for the sink
    assign symbol = cmd.emit_sym ? sym9[7:0] : 8'd0;
    assign count  = cmd.emit_sym ? cnt_reg + 16'd1 : cnt_reg;

    always_comb begin
        buf_next  = buf_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        hold_next = hold_reg;
        if (cmd.clear) begin
            buf_next  = '0;
            bits_next = '0;
            cnt_next  = '0;
            hold_next = 1'b0;
        end else if (cmd.load) begin
            buf_next  = {buf_reg[hpack_pkg::BUF_W-9:0], in_byte};
            bits_next = bits_reg + 6'd8;
        end else if (cmd.consume) begin
            bits_next = bits_reg - {1'b0, hit_len};
            cnt_next  = cnt_reg + 16'd1;
        end else if (cmd.set_hold) begin
            hold_next = 1'b1;
        end
    end

    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= 6'd37) else $error("bit buffer overrun");
    a_consume_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.consume |-> hit && !sym9[8]) else $error("consume without match");
    a_hold_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_hold |=> hold_reg) else $error("hold not set");
endmodule

FILE: src/hpack_huffman_decoder.sv
// ---------------------------------------------------------------------------
// hpack_huffman_decoder
// rfc 7541 static huffman string decoder, one coded byte per word in
// ---------------------------------------------------------------------------
// sequence: a byte is taken only in idle, then its symbols are drained until no code
//   matches or an error is reported; a final byte then gets a closing word; no new
//   byte is taken until the last one is through; bytes after an error are dropped;
//   the single matcher resolves one code per cycle while the sink is ready
// reset: aresetn synchronous active low clears buffer, counts, error hold,
//   and sets output_limit to 65535
module hpack_huffman_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // code_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // symbol[7:0], status[10:8], decoded_count[26:11]
    output logic        m_tlast,   // string_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // output_limit
);
    hpack_pkg::hpack_cmd_t  cmd;
    hpack_pkg::hpack_stat_t stat;

    logic [15:0] limit_reg;
    logic [7:0]  symbol;
    logic [15:0] count;
    logic [2:0]  status;

    // configuration register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 16'hffff;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    hpack_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_last    (s_tlast),
        .stat       (stat),
        .cmd        (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_done   (m_tlast),
        .out_status (status)
    );

    hpack_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_byte      (s_tdata),
        .output_limit (limit_reg),
        .stat         (stat),
        .symbol       (symbol),
        .count        (count)
    );

    // result word packed lowest field first
    assign m_tdata = {5'd0, count, status, symbol};
endmodule
